// ===== rtl/dhtl_pkg.sv =====
package dhtl_pkg;

    localparam int REG_W    = 11;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int REM_STEP = 4;

    localparam logic [REG_W-1:0] TABLE_SIZE_RST   = 11'd10;
    localparam logic [REG_W-1:0] HASH_MODULUS_RST = 11'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODULUS = 2'd1;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/dhtl_if.sv =====
interface dhtl_req_if import dhtl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [KEY_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink (input valid, input operation, input key, output ready);
endinterface

interface dhtl_rsp_if import dhtl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink (input valid, input status, input slot_index, output ready);
endinterface

// ===== rtl/dhtl_ram.sv =====
module dhtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dhtl_rem.sv =====
module dhtl_rem import dhtl_pkg::*;
#(
    parameter int DIVIDEND_W = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [REG_W-1:0]      divisor,
    output logic                  done,
    output logic [REG_W-1:0]      remainder
);

    localparam int CYCLES = (DIVIDEND_W + REM_STEP - 1) / REM_STEP;
    localparam int PAD_W  = CYCLES * REM_STEP;
    localparam int CNT_W  = $clog2(CYCLES + 1);

    logic [PAD_W-1:0] num_reg, num_next;
    logic [REG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             busy;
    logic [REG_W-1:0] partial;

    assign busy = (cnt_reg != '0);

    // restoring steps, one dividend bit each
    always_comb
    begin
        logic [REG_W:0] trial;
        partial = rem_reg;
        for (int k = 0; k < REM_STEP; k++)
        begin
            trial = {partial, num_reg[PAD_W-1-k]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            partial = trial[REG_W-1:0];
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = busy && (cnt_reg == CNT_W'(1));
        if (start)
        begin
            num_next = PAD_W'(dividend);
            rem_next = '0;
            cnt_next = CNT_W'(CYCLES);
        end
        else if (busy)
        begin
            num_next = num_reg << REM_STEP;
            rem_next = partial;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/double_hash_table_insert_lookup.sv =====
// Flow: the key is reduced modulo the hash modulus at 4 bits a cycle, then the hash is
// reduced modulo the table size to give the start slot and the probe step, and slots are
// then probed one by one until a free slot, a match or the last probe; the next request
// is taken once the previous result sits in the output register.
// Reset: registers return to size 10 and modulus 7; a clearing pass over all
// TABLE_DEPTH slots then marks every slot empty before requests are taken.
module double_hash_table_insert_lookup import dhtl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    dhtl_req_if.sink             req,
    dhtl_rsp_if.source           rsp
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = KEY_W + 1;

    state_t state_reg, state_next;

    logic [REG_W-1:0] table_size_reg, hash_modulus_reg;
    logic [REG_W-1:0] size_w, mod_w;

    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [REG_W-1:0] pos_reg, pos_next;
    logic [REG_W-1:0] step_reg, step_next;
    logic [REG_W-1:0] probe_reg, probe_next;
    status_t          res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;

    logic              rsp_valid_reg, rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    logic [SLOT_W-1:0] rsp_slot_reg, rsp_slot_next;

    logic               accept;
    logic               emit;
    logic               start_hash, start_reduce;
    logic               hash_done, reduce_done;
    logic [REG_W-1:0]   h1, pos_init, step_init;
    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
    logic               entry_used, entry_match, last_probe;
    logic [REG_W:0]     pos_sum;
    logic [REG_W-1:0]   pos_wrap;

    always_comb
    begin
        size_w = table_size_reg;
        if (table_size_reg == '0)
        begin
            size_w = REG_W'(1);
        end
        else if (32'(table_size_reg) > TABLE_DEPTH)
        begin
            size_w = REG_W'(TABLE_DEPTH);
        end
        mod_w = (hash_modulus_reg == '0) ? REG_W'(1) : hash_modulus_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= TABLE_SIZE_RST;
            hash_modulus_reg <= HASH_MODULUS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE:   table_size_reg   <= cfg_data;
                CFG_HASH_MODULUS: hash_modulus_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    dhtl_rem #(.DIVIDEND_W(KEY_W)) u_rem_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_hash),
        .dividend  (key_next),
        .divisor   (mod_w),
        .done      (hash_done),
        .remainder (h1)
    );

    dhtl_rem #(.DIVIDEND_W(REG_W)) u_rem_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reduce),
        .dividend  (h1),
        .divisor   (size_w),
        .done      (reduce_done),
        .remainder (pos_init)
    );

    dhtl_rem #(.DIVIDEND_W(REG_W)) u_rem_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reduce),
        .dividend  (mod_w - h1),
        .divisor   (size_w),
        .done      (),
        .remainder (step_init)
    );

    dhtl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign accept      = req.valid && req.ready;
    assign emit        = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp.ready);
    assign entry_used  = ram_rd_data[KEY_W];
    assign entry_match = (op_reg == OP_LOOKUP) && (ram_rd_data[KEY_W-1:0] == key_reg);
    assign last_probe  = ((probe_reg + REG_W'(1)) == size_w);
    assign pos_sum     = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_wrap    = (pos_sum >= {1'b0, size_w}) ?
                         REG_W'(pos_sum - {1'b0, size_w}) : pos_sum[REG_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (reduce_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!entry_used || entry_match || last_probe)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        start_hash      = 1'b0;
        start_reduce    = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = AW'(pos_reg);
        ram_wr_data     = {1'b1, key_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = AW'(pos_reg);
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(req.operation);
                    key_next   = req.key;
                    start_hash = 1'b1;
                end
            end
            S_HASH:
            begin
                start_reduce = hash_done;
            end
            S_REDUCE:
            begin
                if (reduce_done)
                begin
                    pos_next    = pos_init;
                    step_next   = step_init;
                    probe_next  = '0;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(pos_init);
                end
            end
            S_CHECK:
            begin
                if (!entry_used)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        ram_wr_en       = 1'b1;
                        res_status_next = ST_INSERTED;
                        res_slot_next   = pos_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                    end
                end
                else if (entry_match)
                begin
                    res_status_next = ST_FOUND;
                    res_slot_next   = pos_reg[SLOT_W-1:0];
                end
                else if (last_probe)
                begin
                    res_status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    res_slot_next   = '0;
                end
                else
                begin
                    // advance to the next probe and fetch it
                    pos_next    = pos_wrap;
                    probe_next  = probe_reg + REG_W'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(pos_wrap);
                end
            end
            S_EMIT:  ;
            default: ;
        endcase
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        if (emit)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = res_status_reg;
            rsp_slot_next   = res_slot_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        probe_reg      <= probe_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.slot_index = rsp_slot_reg;

endmodule
